// ===== sv/utf8d_pkg.sv =====
package utf8d_pkg;

   localparam logic [15:0] ReplacementCp = 16'hFFFD;
   localparam logic [7:0]  LeadMask2     = 8'hE0;
   localparam logic [7:0]  LeadCode2     = 8'hC0;
   localparam logic [7:0]  LeadMask3     = 8'hF0;
   localparam logic [7:0]  LeadCode3     = 8'hE0;
   localparam logic [7:0]  LeadMask4     = 8'hF8;
   localparam logic [7:0]  LeadCode4     = 8'hF0;
   localparam logic [7:0]  Payload2Mask  = 8'h1F;
   localparam logic [7:0]  Payload3Mask  = 8'h0F;
   localparam logic [7:0]  ContMask      = 8'h3F;

   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [15:0] code_point;
      logic [1:0]  bytes_used;
      logic        end_of_string;
   } result_type;

   typedef struct packed {
      logic [1:0] push_count;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ===== sv/utf8d_decode.sv =====
module utf8d_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            in_byte,
   output utf8d_pkg::push_type   push
);

   logic [1:0] bytes_pending_ff, bytes_pending_in;
   logic       skipping_long_ff, skipping_long_in;
   logic [1:0] sequence_length_ff, sequence_length_in;
   logic [9:0] partial_value_ff, partial_value_in;

   utf8d_pkg::result_type end_marker;
   utf8d_pkg::result_type replacement;

   always_comb begin
      end_marker  = '{code_point: 16'h0000, bytes_used: 2'd0, end_of_string: 1'b1};
      replacement = '{code_point: utf8d_pkg::ReplacementCp, bytes_used: 2'd1,
                      end_of_string: 1'b0};

      bytes_pending_in   = bytes_pending_ff;
      skipping_long_in   = skipping_long_ff;
      sequence_length_in = sequence_length_ff;
      partial_value_in   = partial_value_ff;
      push.push_count    = 2'd0;
      push.first         = end_marker;
      push.second        = end_marker;

      if (in_byte == 8'h00) begin
         if (bytes_pending_ff != 2'd0 && !skipping_long_ff) begin
            push.push_count        = 2'd2;
            push.first             = replacement;
            push.first.bytes_used  = sequence_length_ff - bytes_pending_ff;
         end else begin
            push.push_count = 2'd1;
         end
         bytes_pending_in   = 2'd0;
         skipping_long_in   = 1'b0;
         sequence_length_in = 2'd0;
         partial_value_in   = 10'd0;
      end else if (bytes_pending_ff != 2'd0) begin
         if (skipping_long_ff) begin
            bytes_pending_in = bytes_pending_ff - 2'd1;
            if (bytes_pending_ff == 2'd1) begin
               skipping_long_in = 1'b0;
            end
         end else if (bytes_pending_ff == 2'd1) begin
            push.push_count          = 2'd1;
            push.first.code_point    = {partial_value_ff, in_byte[5:0]};
            push.first.bytes_used    = sequence_length_ff;
            push.first.end_of_string = 1'b0;
            bytes_pending_in         = 2'd0;
            skipping_long_in         = 1'b0;
            sequence_length_in       = 2'd0;
            partial_value_in         = 10'd0;
         end else begin
            partial_value_in = {partial_value_ff[3:0], in_byte[5:0]};
            bytes_pending_in = bytes_pending_ff - 2'd1;
         end
      end else if (!in_byte[7]) begin
         push.push_count          = 2'd1;
         push.first.code_point    = {8'h00, in_byte};
         push.first.bytes_used    = 2'd1;
         push.first.end_of_string = 1'b0;
      end else if ((in_byte & utf8d_pkg::LeadMask2) == utf8d_pkg::LeadCode2) begin
         bytes_pending_in   = 2'd1;
         sequence_length_in = 2'd2;
         partial_value_in   = {2'b00, in_byte & utf8d_pkg::Payload2Mask};
      end else if ((in_byte & utf8d_pkg::LeadMask3) == utf8d_pkg::LeadCode3) begin
         bytes_pending_in   = 2'd2;
         sequence_length_in = 2'd3;
         partial_value_in   = {2'b00, in_byte & utf8d_pkg::Payload3Mask};
      end else if ((in_byte & utf8d_pkg::LeadMask4) == utf8d_pkg::LeadCode4) begin
         bytes_pending_in   = 2'd3;
         skipping_long_in   = 1'b1;
         sequence_length_in = 2'd0;
         partial_value_in   = 10'd0;
      end else begin
         push.push_count = 2'd1;
         push.first      = replacement;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_pending_ff   <= 2'd0;
         skipping_long_ff   <= 1'b0;
         sequence_length_ff <= 2'd0;
         partial_value_ff   <= 10'd0;
      end else if (step) begin
         bytes_pending_ff   <= bytes_pending_in;
         skipping_long_ff   <= skipping_long_in;
         sequence_length_ff <= sequence_length_in;
         partial_value_ff   <= partial_value_in;
      end
   end

endmodule

// ===== sv/utf8d_queue.sv =====
module utf8d_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_en,
   input  utf8d_pkg::push_type     push,
   output logic                    room,
   output logic                    out_valid,
   input  logic                    out_ready,
   output utf8d_pkg::result_type   out_data
);

   utf8d_pkg::result_type entry_ff [utf8d_pkg::QueueDepth];

   logic [utf8d_pkg::QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [utf8d_pkg::QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [utf8d_pkg::QueueCntW-1:0] count_ff, count_in;
   logic [utf8d_pkg::QueuePtrW-1:0] wr_next;
   logic [1:0]                      pushed;
   logic                            pop;

   localparam logic [utf8d_pkg::QueueCntW-1:0] RoomLimit =
      utf8d_pkg::QueueCntW'(utf8d_pkg::QueueDepth - 2);

   assign room      = (count_ff <= RoomLimit);
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign pushed    = push_en ? push.push_count : 2'd0;
   assign wr_next   = wr_ptr_ff + utf8d_pkg::QueuePtrW'(1);

   always_comb begin
      rd_ptr_in = rd_ptr_ff + utf8d_pkg::QueuePtrW'(pop);
      wr_ptr_in = wr_ptr_ff + utf8d_pkg::QueuePtrW'(pushed);
      count_in  = count_ff + utf8d_pkg::QueueCntW'(pushed)
                  - utf8d_pkg::QueueCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pushed != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (pushed == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

// ===== sv/utf8_codepoint_decoder.sv =====
// UTF-8 to code point decoder. One byte enters per transfer on req_; code points
// leave on rsp_. Two- and three-byte sequences are assembled without checking
// continuation bytes, four-byte sequences are dropped, stray continuation bytes
// and leads of 0xF8 and up give U+FFFD. A zero byte closes the string with an
// end marker (tlast high, code point and byte count zero), preceded by U+FFFD
// if it cut a two- or three-byte sequence short. A byte is registered on entry and
// decoded from that register into a four-entry result queue once the queue has
// room for two results, so a new byte is taken every cycle as long as the queue has
// that room, and the queue alone bounds throughput under rsp_ stall.
module utf8_codepoint_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] code_point, [17:16] bytes_used, rest zero
   output logic        rsp_tlast    // end_of_string
);

   logic                  byte_valid_ff, byte_valid_in;
   logic [7:0]            byte_ff;
   logic                  room;
   logic                  step;
   utf8d_pkg::push_type   push;
   utf8d_pkg::result_type head;

   assign step          = byte_valid_ff && room;
   assign req_tready    = !byte_valid_ff || room;
   assign byte_valid_in = req_tvalid || (byte_valid_ff && !room);

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
      end else begin
         byte_valid_ff <= byte_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         byte_ff <= req_tdata;
      end
   end

   utf8d_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .in_byte (byte_ff),
      .push    (push)
   );

   utf8d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (step),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head)
   );

   assign rsp_tdata = {6'b000000, head.bytes_used, head.code_point};
   assign rsp_tlast = head.end_of_string;

endmodule

// ===== sv/utf8d_checker.sv =====
module utf8d_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid && req_tready)
      else $error("result valid or input blocked right after reset");

   a_end_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[17:0] == 18'd0)
      else $error("end marker carries data");

   a_used_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[17:16] != 2'd0)
      else $error("code point with zero byte count");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:18] == 6'd0)
      else $error("tdata padding not zero");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind utf8_codepoint_decoder utf8d_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
